// ----- rtl/uart_rx_command_decoder_defines.svh -----
// ---------------------------------------------------------------------------
// uart rx command decoder assertion macros
// shared concurrent assertion forms, clocked on clk_i, held off in reset
// ---------------------------------------------------------------------------
`ifndef UART_RX_COMMAND_DECODER_DEFINES_SVH
`define UART_RX_COMMAND_DECODER_DEFINES_SVH

// same-cycle implication
`define URCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/urcd_pkg.sv -----
// ---------------------------------------------------------------------------
// urcd package
// types, constants and command codes shared across the uart rx decoder
// ---------------------------------------------------------------------------
package urcd_pkg;

  // serial framing
  localparam int unsigned NUM_BITS    = 8;
  localparam int unsigned BIT_IDX_W   = $clog2(NUM_BITS);
  localparam int unsigned BIT_TICKS_W = 16;
  // bit_ticks plus half of it fits one extra bit
  localparam int unsigned TARGET_W    = BIT_TICKS_W + 1;

  localparam int unsigned COUNTER_WIDTH_DEF = 17;

  localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST = 16'd104;

  // apb port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_BIT_TICKS = 1'b0
  } reg_idx_e;

  // command bytes
  localparam logic [7:0] CMD_RAW  = 8'h52; // 'R'
  localparam logic [7:0] CMD_FAST = 8'h46; // 'F'
  localparam logic [7:0] CMD_SLOW = 8'h4F; // 'O'
  localparam logic [7:0] CMD_STOP = 8'h53; // 'S'
  localparam logic [7:0] CMD_SEND = 8'h44; // 'D'

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_FAST   = 3'd1,
    MODE_SLOW   = 3'd2,
    MODE_HALT   = 3'd3,
    MODE_PUSH   = 3'd4
  } report_mode_e;

  // byte completion event from the sampler
  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] value;
  } rx_byte_t;

  // decoder state after this tick
  typedef struct packed {
    report_mode_e mode;
    logic         raw;
  } cmd_state_t;

endpackage

// ----- rtl/uart_rx_command_decoder.sv -----
// an accepted tick word's result word is registered and shows on the master side in the next cycle
// throughput: one tick word per cycle, held back only while the result register is full
// the result register frees in the same cycle that its word is taken
// reset (rst_ni low, asynchronous): line taken as idle high, receiver idle, mode default,
// raw flag off, bit_ticks back to 104, result register empty
// ---------------------------------------------------------------------------
// uart rx command decoder
// 8-bit lsb-first serial receiver fed one line sample per word, with a
// command decoder for report mode and raw forwarding
// ---------------------------------------------------------------------------
`include "uart_rx_command_decoder_defines.svh"

module uart_rx_command_decoder #(
  parameter int unsigned COUNTER_WIDTH = urcd_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick words in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] rx_level, [7:1] zero
  // result words out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [7:0] byte_value,
                                                         // [10:8] report_mode,
                                                         // [11] raw_output, [15:12] zero
  output logic [0:0]                      m_axis_tuser,  // [0] byte_valid
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [urcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [urcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import urcd_pkg::*;

  logic [BIT_TICKS_W-1:0] bit_ticks;
  logic                   tick_acc;
  rx_byte_t               rx_byte;
  cmd_state_t             cmd_state;

  // result register
  logic                   out_vld_q, out_vld_d;
  logic                   out_byte_vld_q;
  logic [NUM_BITS-1:0]    out_byte_q;
  report_mode_e           out_mode_q;
  logic                   out_raw_q;

  // assertion helpers
  logic                   raw_flip;
  logic                   raw_cmd;
  logic                   mode_ok;

  // a tick may enter whenever the result slot is empty or draining this cycle
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign tick_acc      = s_axis_tvalid && s_axis_tready;

  urcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bit_ticks_o (bit_ticks)
  );

  urcd_sampler #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_sampler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_acc),
    .level_i     (s_axis_tdata[0]),
    .bit_ticks_i (bit_ticks),
    .byte_o      (rx_byte)
  );

  // only fires on a completed byte, which needs an accepted tick
  urcd_cmd_dec u_cmd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (rx_byte),
    .state_o (cmd_state)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (tick_acc) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      out_byte_vld_q <= rx_byte.done;
      out_byte_q     <= rx_byte.value;
      out_mode_q     <= cmd_state.mode;
      out_raw_q      <= cmd_state.raw;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_byte_vld_q;
  assign m_axis_tdata  = {4'b0000, out_raw_q, out_mode_q, out_byte_q};

  assign raw_flip = tick_acc && (cmd_state.raw != out_raw_q) && out_vld_q;
  assign raw_cmd  = rx_byte.done && (rx_byte.value == CMD_RAW);
  assign mode_ok  = (out_mode_q == MODE_NORMAL) || (out_mode_q == MODE_FAST) ||
                    (out_mode_q == MODE_SLOW) || (out_mode_q == MODE_HALT) ||
                    (out_mode_q == MODE_PUSH);

  // byte field reads zero on ticks that complete no byte
  `URCD_ASSERT_NOW(a_byte_zero, out_vld_q && !out_byte_vld_q, out_byte_q == '0, "byte without valid")
  // a stalled input side means a word is waiting
  `URCD_ASSERT_NOW(a_stall_full, !s_axis_tready, out_vld_q, "input stalled with empty slot")
  // raw flag flips only on an 'R' byte
  `URCD_ASSERT_NEXT(a_raw_cmd, raw_flip, $past(raw_cmd), "raw flag changed without command")
  // report mode stays within its defined codes
  `URCD_ASSERT_NOW(a_mode_range, out_vld_q, mode_ok, "report mode out of range")

endmodule

// ----- rtl/urcd_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// urcd configuration registers
// apb-style register file holding the bit period
// ---------------------------------------------------------------------------
module urcd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [urcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [urcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [urcd_pkg::BIT_TICKS_W-1:0] bit_ticks_o
);
  import urcd_pkg::*;

  logic [BIT_TICKS_W-1:0] bit_ticks_q, bit_ticks_d;
  reg_idx_e               reg_idx;
  logic                   in_range;

  // word index sits above the byte offset
  assign reg_idx  = reg_idx_e'(paddr[2]);
  assign in_range = (paddr[APB_ADDR_W-1:2] == '0);

  always_comb begin
    bit_ticks_d = bit_ticks_q;
    if (psel && penable && pwrite && pready && in_range) begin
      case (reg_idx)
        REG_BIT_TICKS: bit_ticks_d = pwdata[BIT_TICKS_W-1:0];
        default:       bit_ticks_d = bit_ticks_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= BIT_TICKS_RST;
    end else begin
      bit_ticks_q <= bit_ticks_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      case (reg_idx)
        REG_BIT_TICKS: prdata = APB_DATA_W'(bit_ticks_q);
        default:       prdata = '0;
      endcase
    end
  end

  assign pready      = 1'b1;
  assign bit_ticks_o = bit_ticks_q;

endmodule

// ----- rtl/urcd_sampler.sv -----
// ---------------------------------------------------------------------------
// urcd bit sampler
// start edge detect, bit period timing and lsb-first shift register
// ---------------------------------------------------------------------------
module urcd_sampler #(
  parameter int unsigned COUNTER_WIDTH = urcd_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             tick_i,
  input  logic                             level_i,
  input  logic [urcd_pkg::BIT_TICKS_W-1:0] bit_ticks_i,
  output urcd_pkg::rx_byte_t               byte_o
);
  import urcd_pkg::*;

  // wide enough for both the counter and the raw target
  localparam int unsigned TW = (COUNTER_WIDTH > TARGET_W) ? COUNTER_WIDTH : TARGET_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic                     prev_q, prev_d;
  logic                     busy_q, busy_d;
  logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
  logic [BIT_IDX_W-1:0]     idx_q, idx_d;
  logic [NUM_BITS-1:0]      shift_q, shift_d;

  logic [TW-1:0]            target_raw;
  logic [COUNTER_WIDTH-1:0] target;
  logic [COUNTER_WIDTH-1:0] cnt_inc;
  logic [NUM_BITS-1:0]      shift_smp;

  always_comb begin
    // first sample one and a half periods after the edge
    if (idx_q == '0) begin
      target_raw = TW'(bit_ticks_i) + TW'(bit_ticks_i >> 1);
    end else begin
      target_raw = TW'(bit_ticks_i);
    end
    if (target_raw > TW'(CNT_MAX)) begin
      target = CNT_MAX;
    end else begin
      target = target_raw[COUNTER_WIDTH-1:0];
    end
    cnt_inc   = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
    shift_smp = shift_q | (NUM_BITS'(level_i) << idx_q);
  end

  always_comb begin
    prev_d  = prev_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    byte_o  = '0;
    if (tick_i) begin
      prev_d = level_i;
      if (busy_q) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= target) begin
          cnt_d   = '0;
          shift_d = shift_smp;
          if (idx_q == BIT_IDX_W'(NUM_BITS - 1)) begin
            busy_d       = 1'b0;
            idx_d        = '0;
            byte_o.done  = 1'b1;
            byte_o.value = shift_smp;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end else if (prev_q && !level_i) begin
        busy_d  = 1'b1;
        cnt_d   = '0;
        idx_d   = '0;
        shift_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else begin
      prev_q  <= prev_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

endmodule

// ----- rtl/urcd_cmd_dec.sv -----
// ---------------------------------------------------------------------------
// urcd command decoder
// report mode and raw flag driven by received command bytes
// ---------------------------------------------------------------------------
module urcd_cmd_dec (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  urcd_pkg::rx_byte_t    byte_i,
  output urcd_pkg::cmd_state_t  state_o
);
  import urcd_pkg::*;

  report_mode_e mode_q, mode_d;
  logic         raw_q, raw_d;

  always_comb begin
    mode_d = mode_q;
    raw_d  = raw_q;
    if (byte_i.done) begin
      case (byte_i.value)
        CMD_RAW:  raw_d  = ~raw_q;
        CMD_FAST: mode_d = MODE_FAST;
        CMD_SLOW: mode_d = MODE_SLOW;
        CMD_STOP: mode_d = MODE_HALT;
        CMD_SEND: mode_d = MODE_PUSH;
        default:  mode_d = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      raw_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      raw_q  <= raw_d;
    end
  end

  // reported state already includes this tick's command
  assign state_o.mode = mode_d;
  assign state_o.raw  = raw_d;

endmodule

// ----- test/tb_uart_rx_command_decoder.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// uart rx command decoder testbench
// line samples are streamed in one word per tick, as framed bytes, cut-off
// frames and noise, over several bit periods; every result word is checked
// against a tick-level model of the sampler and the command decoder
// ---------------------------------------------------------------------------
module tb_uart_rx_command_decoder;
  import urcd_pkg::*;

  localparam int unsigned CNT_W   = COUNTER_WIDTH_DEF;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  // register index with nothing behind it, writes there must be dropped
  localparam int unsigned UNMAPPED_IDX = 1;
  localparam logic [APB_ADDR_W-1:0] BIT_TICKS_ADDR = APB_ADDR_W'(4 * int'(REG_BIT_TICKS));
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR  = APB_ADDR_W'(4 * UNMAPPED_IDX);

  // one result word as the decoder should present it
  typedef struct {
    logic         byte_valid;
    logic [7:0]   byte_value;
    report_mode_e report_mode;
    logic         raw_output;
  } tick_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'hFF; // [0] rx_level, [7:1] zero
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;          // [7:0] byte_value, [10:8] report_mode,
                                                // [11] raw_output, [15:12] zero
  logic [0:0]            m_axis_tuser;          // [0] byte_valid
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // line levels still to be sent, and results still to come back
  logic         line_levels_q[$];
  tick_result_t tick_results_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_request  = 1'b0;
  logic        rx_hold       = 1'b0;
  int unsigned mismatch_cnt  = 0;

  // model state, reset values as the block comes out of reset
  logic [15:0]  bit_ticks_q = BIT_TICKS_RST;
  logic         prev_level  = 1'b1;
  logic         rx_busy     = 1'b0;
  int unsigned  tick_cnt    = 0;
  logic [2:0]   bit_pos     = '0;
  logic [7:0]   shift_q     = '0;
  report_mode_e mode_q      = MODE_NORMAL;
  logic         raw_q       = 1'b0;

  uart_rx_command_decoder #(
    .COUNTER_WIDTH(CNT_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // advance the model by one line sample and queue the word it should give
  function automatic void line_tick(input logic level);
    tick_result_t res;
    int unsigned  target;
    res.byte_valid = 1'b0;
    res.byte_value = '0;
    if (rx_busy) begin
      if (tick_cnt < CNT_MAX) tick_cnt++;
      // first sample lands mid-way into bit 0, one and a half periods on
      target = (bit_pos == 3'd0) ? int'(bit_ticks_q) + int'(bit_ticks_q >> 1)
                                 : int'(bit_ticks_q);
      if (target > CNT_MAX) target = CNT_MAX;
      if (tick_cnt >= target) begin
        shift_q[bit_pos] = shift_q[bit_pos] | level;
        tick_cnt = 0;
        if (bit_pos == 3'd7) begin
          rx_busy        = 1'b0;
          bit_pos        = '0;
          res.byte_valid = 1'b1;
          res.byte_value = shift_q;
          case (shift_q)
            CMD_RAW:  raw_q  = ~raw_q;
            CMD_FAST: mode_q = MODE_FAST;
            CMD_SLOW: mode_q = MODE_SLOW;
            CMD_STOP: mode_q = MODE_HALT;
            CMD_SEND: mode_q = MODE_PUSH;
            default: ;
          endcase
        end else begin
          bit_pos++;
        end
      end
    end else if (prev_level && !level) begin
      // start edge, later edges inside the byte are not looked at
      rx_busy  = 1'b1;
      tick_cnt = 0;
      bit_pos  = '0;
      shift_q  = '0;
    end
    prev_level      = level;
    res.report_mode = mode_q;
    res.raw_output  = raw_q;
    tick_results_q.push_back(res);
  endfunction

  // one framed byte, w samples per bit; keep > 0 cuts the frame short
  function automatic void queue_frame(input logic [7:0] value, input int unsigned w,
                                      input int unsigned keep);
    logic frame[$];
    repeat (1 + $urandom_range(2)) frame.push_back(1'b1);
    repeat (w) frame.push_back(1'b0);
    for (int i = 0; i < 8; i++) repeat (w) frame.push_back(value[i]);
    repeat (w) frame.push_back(1'b1);
    if (keep == 0 || keep > frame.size()) keep = frame.size();
    for (int i = 0; i < keep; i++) line_levels_q.push_back(frame[i]);
  endfunction

  // mostly clean frames, half of them commands, with cut-off frames, off-rate
  // frames and line noise mixed in; a long idle tail lets any byte finish
  function automatic void queue_traffic(input int unsigned bt, input int unsigned n_ticks);
    int unsigned w;
    int unsigned start;
    int unsigned pick;
    logic [7:0]  value;
    w     = (bt == 0) ? 1 : bt;
    start = line_levels_q.size();
    while (line_levels_q.size() - start < n_ticks) begin
      pick  = $urandom_range(99);
      value = 8'($urandom_range(255));
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0:       value = CMD_RAW;
          1:       value = CMD_FAST;
          2:       value = CMD_SLOW;
          3:       value = CMD_STOP;
          default: value = CMD_SEND;
        endcase
      end
      if (pick < 75) begin
        queue_frame(value, w, 0);
      end else if (pick < 85) begin
        queue_frame(value, w, 1 + $urandom_range(10 * w));
      end else if (pick < 95) begin
        repeat (1 + $urandom_range(8)) line_levels_q.push_back(1'($urandom_range(1)));
      end else begin
        queue_frame(value, (w > 1 && $urandom_range(1)) ? w - 1 : w + 1, 0);
      end
    end
    repeat (10 * w + 4) line_levels_q.push_back(1'b1);
  endfunction

  // apb write: setup then access, the register takes it on the access edge
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == BIT_TICKS_ADDR) bit_ticks_q = data[15:0];
  endtask

  // read bit_ticks back, data sampled mid-way through the access cycle
  task automatic check_bit_ticks();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BIT_TICKS_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== 32'(bit_ticks_q)) begin
      $error("bit_ticks: expected %0d, got %0d", bit_ticks_q, prdata);
      mismatch_cnt++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_bit_ticks(input logic [15:0] bt);
    apb_write(BIT_TICKS_ADDR, 32'(bt));
    check_bit_ticks();
  endtask

  // every word sent and every result back; one result per word, so nothing
  // is left inside the block after that
  task automatic wait_drained();
    while (line_levels_q.size() != 0 || s_axis_tvalid || tick_results_q.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // sender: a word is taken when tvalid and tready meet at an edge, and the
  // model is stepped with it right there
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) line_tick(s_axis_tdata[0]);
      if (line_levels_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= {7'b0, line_levels_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: compare each result word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    tick_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tick_results_q.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatch_cnt++;
        end else begin
          want = tick_results_q.pop_front();
          if (m_axis_tuser[0] !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, m_axis_tuser[0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[7:0] !== want.byte_value) begin
            $error("byte_value: expected %0h, got %0h", want.byte_value, m_axis_tdata[7:0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[10:8] !== 3'(want.report_mode)) begin
            $error("report_mode: expected %0d, got %0d", want.report_mode,
                   m_axis_tdata[10:8]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[11] !== want.raw_output) begin
            $error("raw_output: expected %0d, got %0d", want.raw_output, m_axis_tdata[11]);
            mismatch_cnt++;
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the result register fills and the input backs up
  initial begin
    wait (hold_request);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned bt;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value first, then zero ticks per bit: every sample on the next
    // tick, so each byte is taken in a start tick plus eight data ticks
    check_bit_ticks();
    set_bit_ticks(16'd0);
    queue_frame(CMD_RAW, 1, 0);
    queue_frame(CMD_FAST, 1, 0);
    queue_frame(CMD_SLOW, 1, 0);
    queue_frame(CMD_STOP, 1, 0);
    queue_frame(CMD_SEND, 1, 0);
    queue_frame(CMD_RAW, 1, 0);
    wait_drained();

    // random traffic over a spread of bit periods and handshake pacing;
    // the last one with a longer bit period
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin bt = 2;  send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin bt = 3;  send_idle_pct = 78; stall_pct = 0;  end
        2:       begin bt = 1;  send_idle_pct = 0;  stall_pct = 78; end
        3:       begin bt = 5;  send_idle_pct = 20; stall_pct = 20; end
        default: begin bt = 12; send_idle_pct = 20; stall_pct = 20; end
      endcase
      set_bit_ticks(16'(bt));
      queue_traffic(bt, (ph < 4) ? 150 : 200);
      wait_drained();
    end

    // back-pressure: sender keeps offering while the receiver holds off
    send_idle_pct = 0;
    stall_pct     = 0;
    set_bit_ticks(16'd4);
    hold_request = 1'b1;
    queue_traffic(4, 250);
    wait_drained();

    // top of the register range, line left idle so no byte starts
    set_bit_ticks(16'hFFFF);
    repeat (40) line_levels_q.push_back(1'b1);
    wait_drained();

    // write to an unmapped index must leave bit_ticks alone
    apb_write(UNMAPPED_ADDR, 32'h0000_0007);
    check_bit_ticks();
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
